/* sv/cpu_8bit_bcd_execute_unit_defines.svh */
// Assertion macros for the execute unit checker.
`ifndef CPU_8BIT_BCD_EXECUTE_UNIT_DEFINES_SVH
`define CPU_8BIT_BCD_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define CBEU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define CBEU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cbeu_pkg.sv */
package cbeu_pkg;

    typedef enum logic [5:0] {
        OP_ADC, OP_AND, OP_ASL, OP_BCC, OP_BCS, OP_BEQ, OP_BIT, OP_BMI, OP_BNE, OP_BPL,
        OP_BRK, OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_CMP, OP_CPX, OP_CPY,
        OP_DEC, OP_DEX, OP_DEY, OP_EOR, OP_INC, OP_INX, OP_INY, OP_JMP, OP_JSR, OP_LDA,
        OP_LDX, OP_LDY, OP_LSR, OP_NOP, OP_ORA, OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_ROL,
        OP_ROR, OP_RTI, OP_RTS, OP_SBC, OP_SEC, OP_SED, OP_SEI, OP_STA, OP_STX, OP_STY,
        OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [7:0]         operand;
        logic               acc_mode;
        logic [15:0]        target;
        logic signed [7:0]  offset;
        logic [15:0]        next_pc;
    } t_in_word;

    typedef struct packed {
        logic        mem_write;
        logic [7:0]  mem_data;
        logic [15:0] new_pc;
        logic [7:0]  acc;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  flags;
        logic [7:0]  stack_ptr;
    } t_out_word;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } t_regs;

    typedef logic [2:0][7:0] t_pull;

    localparam int unsigned StackDepth = 256;
    localparam int unsigned StackAw    = $clog2(StackDepth);
    localparam logic [7:0]  SpReset    = 8'hFD;
    localparam logic [7:0]  PReset     = 8'h24;
    localparam logic [7:0]  FlB        = 8'h10;
    localparam logic [7:0]  Fl1        = 8'h20;
    localparam logic [2:0]  RegBvAddr  = 3'd0;

    function automatic logic [1:0] acc_count(t_op op);
        unique case (op)
            OP_BRK, OP_RTI:                 acc_count = 2'd3;
            OP_JSR, OP_RTS:                 acc_count = 2'd2;
            OP_PHA, OP_PHP, OP_PLA, OP_PLP: acc_count = 2'd1;
            default:                        acc_count = 2'd0;
        endcase
    endfunction

    function automatic logic is_push(t_op op);
        is_push = (op == OP_BRK) || (op == OP_JSR) || (op == OP_PHA) || (op == OP_PHP);
    endfunction

endpackage

/* sv/cbeu_ram.sv */
module cbeu_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/cbeu_alu.sv */
module cbeu_alu (
    input  cbeu_pkg::t_in_word  i_item,
    input  cbeu_pkg::t_regs     i_regs,
    input  cbeu_pkg::t_pull     i_pull,
    input  logic [15:0]         i_bv,
    output cbeu_pkg::t_out_word o_res,
    output cbeu_pkg::t_regs     o_regs
);

    always_comb begin
        logic [7:0]  a, x, y, sp, p, v, m, nz;
        logic [15:0] pc, rel, s;
        logic [8:0]  sum, cmpd;
        logic [5:0]  lo;
        logic [9:0]  hi;
        logic        wr, modify, take, setnz, c;

        a = i_regs.a; x = i_regs.x; y = i_regs.y; sp = i_regs.sp; p = i_regs.p;
        v = i_item.operand;
        c = i_regs.p[0];
        pc = i_item.next_pc;
        rel = {{8{i_item.offset[7]}}, i_item.offset};
        wr = 1'b0; m = 8'h00; modify = 1'b0; take = 1'b0; setnz = 1'b0; nz = 8'h00;
        sum = 9'h000; cmpd = 9'h000; lo = 6'h00; hi = 10'h000; s = 16'h0000;

        unique case (i_item.op)
            cbeu_pkg::OP_ADC, cbeu_pkg::OP_SBC: begin
                if (i_regs.p[3] && i_item.op == cbeu_pkg::OP_ADC) begin
                    lo = {2'b00, a[3:0]} + {2'b00, v[3:0]} + {5'b0, c};
                    hi = {2'b00, a[7:4], 4'h0} + {2'b00, v[7:4], 4'h0};
                    if (lo > 6'h09) begin
                        hi = hi + 10'h010;
                        lo = lo + 6'h06;
                    end
                    if (hi > 10'h090) hi = hi + 10'h060;
                    p[0] = hi[9:8] != 2'b00;
                    a = {hi[7:4], lo[3:0]};
                end else if (i_regs.p[3]) begin
                    s = {8'h00, a} - {12'h000, v[3:0]} + {15'h0, c} - 16'd1;
                    if (s[3:0] > a[3:0]) s = s - 16'd6;
                    s = s - {8'h00, v[7:4], 4'h0};
                    if ({s[15:4], 4'h0} > {8'h00, a[7:4], 4'h0}) s = s - 16'h0060;
                    p[0] = s <= {8'h00, a};
                    a = s[7:0];
                end else begin
                    if (i_item.op == cbeu_pkg::OP_SBC) v = ~v;
                    sum = {1'b0, a} + {1'b0, v} + {8'h00, c};
                    p[0] = sum[8];
                    p[6] = (sum[7] ^ a[7]) & (sum[7] ^ v[7]);
                    a = sum[7:0];
                end
                setnz = 1'b1; nz = a;
            end
            cbeu_pkg::OP_AND: begin a = a & v; setnz = 1'b1; nz = a; end
            cbeu_pkg::OP_ORA: begin a = a | v; setnz = 1'b1; nz = a; end
            cbeu_pkg::OP_EOR: begin a = a ^ v; setnz = 1'b1; nz = a; end
            cbeu_pkg::OP_ASL: begin m = {v[6:0], 1'b0}; p[0] = v[7]; modify = 1'b1; end
            cbeu_pkg::OP_ROL: begin m = {v[6:0], c};    p[0] = v[7]; modify = 1'b1; end
            cbeu_pkg::OP_LSR: begin m = {1'b0, v[7:1]}; p[0] = v[0]; modify = 1'b1; end
            cbeu_pkg::OP_ROR: begin m = {c, v[7:1]};    p[0] = v[0]; modify = 1'b1; end
            cbeu_pkg::OP_INC: begin m = v + 8'd1; modify = 1'b1; end
            cbeu_pkg::OP_DEC: begin m = v - 8'd1; modify = 1'b1; end
            cbeu_pkg::OP_BCC: take = !i_regs.p[0];
            cbeu_pkg::OP_BCS: take = i_regs.p[0];
            cbeu_pkg::OP_BEQ: take = i_regs.p[1];
            cbeu_pkg::OP_BNE: take = !i_regs.p[1];
            cbeu_pkg::OP_BMI: take = i_regs.p[7];
            cbeu_pkg::OP_BPL: take = !i_regs.p[7];
            cbeu_pkg::OP_BVC: take = !i_regs.p[6];
            cbeu_pkg::OP_BVS: take = i_regs.p[6];
            cbeu_pkg::OP_BIT: begin
                p[1] = (a & v) == 8'h00;
                p[7:6] = v[7:6];
            end
            cbeu_pkg::OP_BRK: begin
                p[2] = 1'b1; p[3] = 1'b0; pc = i_bv;
            end
            cbeu_pkg::OP_CLC: p[0] = 1'b0;
            cbeu_pkg::OP_CLD: p[3] = 1'b0;
            cbeu_pkg::OP_CLI: p[2] = 1'b0;
            cbeu_pkg::OP_CLV: p[6] = 1'b0;
            cbeu_pkg::OP_SEC: p[0] = 1'b1;
            cbeu_pkg::OP_SED: p[3] = 1'b1;
            cbeu_pkg::OP_SEI: p[2] = 1'b1;
            cbeu_pkg::OP_CMP, cbeu_pkg::OP_CPX, cbeu_pkg::OP_CPY: begin
                if (i_item.op == cbeu_pkg::OP_CMP) cmpd = {1'b0, a} - {1'b0, v};
                else if (i_item.op == cbeu_pkg::OP_CPX) cmpd = {1'b0, x} - {1'b0, v};
                else cmpd = {1'b0, y} - {1'b0, v};
                p[0] = !cmpd[8];
                setnz = 1'b1; nz = cmpd[7:0];
            end
            cbeu_pkg::OP_DEX: begin x = x - 8'd1; setnz = 1'b1; nz = x; end
            cbeu_pkg::OP_DEY: begin y = y - 8'd1; setnz = 1'b1; nz = y; end
            cbeu_pkg::OP_INX: begin x = x + 8'd1; setnz = 1'b1; nz = x; end
            cbeu_pkg::OP_INY: begin y = y + 8'd1; setnz = 1'b1; nz = y; end
            cbeu_pkg::OP_JMP, cbeu_pkg::OP_JSR: pc = i_item.target;
            cbeu_pkg::OP_RTS: pc = {i_pull[1], i_pull[0]} + 16'd1;
            cbeu_pkg::OP_RTI: begin p = i_pull[0]; pc = {i_pull[2], i_pull[1]}; end
            cbeu_pkg::OP_LDA: begin a = v; setnz = 1'b1; nz = a; end
            cbeu_pkg::OP_LDX: begin x = v; setnz = 1'b1; nz = x; end
            cbeu_pkg::OP_LDY: begin y = v; setnz = 1'b1; nz = y; end
            cbeu_pkg::OP_PLA: begin a = i_pull[0]; setnz = 1'b1; nz = a; end
            cbeu_pkg::OP_PLP: p = i_pull[0] | cbeu_pkg::Fl1;
            cbeu_pkg::OP_STA: begin wr = 1'b1; m = a; end
            cbeu_pkg::OP_STX: begin wr = 1'b1; m = x; end
            cbeu_pkg::OP_STY: begin wr = 1'b1; m = y; end
            cbeu_pkg::OP_TAX: begin x = a; setnz = 1'b1; nz = x; end
            cbeu_pkg::OP_TAY: begin y = a; setnz = 1'b1; nz = y; end
            cbeu_pkg::OP_TSX: begin x = sp; setnz = 1'b1; nz = x; end
            cbeu_pkg::OP_TXA: begin a = x; setnz = 1'b1; nz = a; end
            cbeu_pkg::OP_TXS: sp = x;
            cbeu_pkg::OP_TYA: begin a = y; setnz = 1'b1; nz = a; end
            default: ;
        endcase

        if (modify) begin
            setnz = 1'b1; nz = m;
            if (i_item.acc_mode) begin
                a = m; m = 8'h00;
            end else begin
                wr = 1'b1;
            end
        end
        if (setnz) begin
            p[1] = nz == 8'h00;
            p[7] = nz[7];
        end
        if (take) pc = pc + rel;

        o_res.mem_write = wr;
        o_res.mem_data  = wr ? m : 8'h00;
        o_res.new_pc    = pc;
        o_res.acc       = a;
        o_res.index_x   = x;
        o_res.index_y   = y;
        o_res.flags     = p;
        o_res.stack_ptr = sp;
        o_regs.a  = a;
        o_regs.x  = x;
        o_regs.y  = y;
        o_regs.sp = sp;
        o_regs.p  = p;
    end

endmodule

/* sv/cpu_8bit_bcd_execute_unit.sv */
// Words without stack traffic go through the ALU into the output register; stack words first
// push or pull their bytes one at a time through the stack page RAM (pulls via its registered read).
// Throughput: 1 word per cycle without stack traffic while i_stall does not hold the output;
// stack words hold o_stall until their stack bytes are moved, and a new word is taken as one leaves.
// Reset: A=X=Y=0, SP=FD, P=24, break vector 0, all stack bytes read as zero.
module cpu_8bit_bcd_execute_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cbeu_pkg::t_in_word   i_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cbeu_pkg::t_out_word  o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    cbeu_pkg::t_in_word  r_item;
    cbeu_pkg::t_out_word r_out, alu_res;
    cbeu_pkg::t_regs     r_regs, alu_regs, n_regs;
    cbeu_pkg::t_pull     r_pull;
    logic                r_busy, r_pend, r_rvld, r_ovalid;
    logic [1:0]          r_cnt;
    logic [15:0]         r_bv;
    logic [cbeu_pkg::StackDepth-1:0] r_vld;

    logic [1:0]  need_n;
    logic        push, step, fin, out_free, go, accept, we;
    logic [7:0]  raddr, wdata, rdata;
    logic [15:0] pc_m1, pc_p1;

    assign need_n   = cbeu_pkg::acc_count(r_item.op);
    assign push     = cbeu_pkg::is_push(r_item.op);
    assign step     = r_busy && (r_cnt != need_n);
    assign fin      = r_busy && (r_cnt == need_n) && !r_pend;
    assign out_free = !r_ovalid || !i_stall;
    assign go       = fin && out_free;
    assign o_stall  = r_busy && !go;
    assign accept   = i_valid && !o_stall;
    assign we       = step && push;
    assign raddr    = r_regs.sp + 8'd1;
    assign pc_m1    = r_item.next_pc - 16'd1;
    assign pc_p1    = r_item.next_pc + 16'd1;

    always_comb begin
        wdata = r_regs.a;
        case (r_item.op)
            cbeu_pkg::OP_JSR: wdata = (r_cnt == 2'd0) ? pc_m1[15:8] : pc_m1[7:0];
            cbeu_pkg::OP_BRK: begin
                if (r_cnt == 2'd0) wdata = pc_p1[15:8];
                else if (r_cnt == 2'd1) wdata = pc_p1[7:0];
                else wdata = r_regs.p | cbeu_pkg::FlB;
            end
            cbeu_pkg::OP_PHP: wdata = r_regs.p | cbeu_pkg::FlB;
            default: wdata = r_regs.a;
        endcase
    end

    cbeu_ram #(
        .Width (8),
        .Depth (cbeu_pkg::StackDepth)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_regs.sp),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cbeu_alu u_alu (
        .i_item (r_item),
        .i_regs (r_regs),
        .i_pull (r_pull),
        .i_bv   (r_bv),
        .o_res  (alu_res),
        .o_regs (alu_regs)
    );

    always_comb begin
        n_regs = r_regs;
        if (step) begin
            n_regs.sp = push ? r_regs.sp - 8'd1 : raddr;
        end else if (go) begin
            n_regs = alu_regs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= 2'd0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_vld    <= '0;
            r_bv     <= 16'h0000;
            r_regs   <= '{a: 8'h00, x: 8'h00, y: 8'h00,
                          sp: cbeu_pkg::SpReset, p: cbeu_pkg::PReset};
        end else begin
            r_regs <= n_regs;
            r_pend <= step && !push;
            if (step) r_cnt <= r_cnt + 2'd1;
            if (we) r_vld[r_regs.sp] <= 1'b1;
            if (accept) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (go) begin
                r_busy <= 1'b0;
            end
            if (go) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            if (psel && penable && pwrite && pready && paddr[2] == cbeu_pkg::RegBvAddr[2]) begin
                r_bv <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rvld <= r_vld[raddr];
        if (accept) r_item <= i_in;
        if (r_pend) r_pull[r_cnt - 2'd1] <= r_rvld ? rdata : 8'h00;
        if (go) r_out <= alu_res;
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == cbeu_pkg::RegBvAddr[2]) ? {16'h0000, r_bv} : 32'h0000_0000;

endmodule

/* sv/cbeu_checker.sv */
`include "cpu_8bit_bcd_execute_unit_defines.svh"

module cbeu_sva (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input cbeu_pkg::t_out_word o_out
);

    `CBEU_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid, "word dropped while stalled")
    `CBEU_ASSERT_NXT(a_out_stable, o_valid && i_stall, $stable(o_out), "word changed while stalled")
    `CBEU_ASSERT_IMP(a_wd_zero, o_valid && !o_out.mem_write, o_out.mem_data == 8'h00,
        "write data without write")

endmodule

bind cpu_8bit_bcd_execute_unit cbeu_sva u_cbeu_sva (.*);

/* verif/cbeu_checker.sv */
`timescale 1ns / 1ps
module cbeu_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  cbeu_pkg::t_in_word   i_in,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  cbeu_pkg::t_out_word  o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    output int                   o_errors,
    output int                   o_pending
);

    localparam logic [7:0] FC = 8'h01, FZ = 8'h02, FI = 8'h04, FD = 8'h08;
    localparam logic [7:0] FV = 8'h40, FN = 8'h80;

    logic [7:0]  a_r, x_r, y_r, sp_r, p_r;
    logic [7:0]  stk [256];
    logic [15:0] brk_vec;
    cbeu_pkg::t_out_word exp_words[$];
    int          errors;
    int          pending;

    assign o_errors  = errors;
    assign o_pending = pending;

    function automatic void put_flag(logic [7:0] f, logic on);
        if (on) p_r = p_r | f;
        else p_r = p_r & ~f;
    endfunction

    function automatic void set_nz(logic [7:0] v);
        put_flag(FZ, v == 8'h00);
        put_flag(FN, v[7]);
    endfunction

    function automatic void push8(logic [7:0] v);
        stk[sp_r] = v;
        sp_r = sp_r - 8'd1;
    endfunction

    function automatic logic [7:0] pull8();
        sp_r = sp_r + 8'd1;
        return stk[sp_r];
    endfunction

    function automatic void compare(logic [7:0] r, logic [7:0] v);
        logic [7:0] d;
        d = r - v;
        put_flag(FC, r >= v);
        put_flag(FZ, r == v);
        put_flag(FN, d[7]);
    endfunction

    function automatic void add_bin(logic [7:0] v);
        logic [8:0] r;
        r = {1'b0, a_r} + {1'b0, v} + {8'd0, p_r[0]};
        put_flag(FC, r[8]);
        put_flag(FV, ((r[7:0] ^ a_r) & (r[7:0] ^ v) & 8'h80) != 8'h00);
        set_nz(r[7:0]);
        a_r = r[7:0];
    endfunction

    function automatic void adc_dec(logic [7:0] v);
        logic [15:0] lo, hi;
        logic [7:0]  r;
        lo = {12'd0, a_r[3:0]} + {12'd0, v[3:0]} + {15'd0, p_r[0]};
        hi = {8'd0, a_r & 8'hF0} + {8'd0, v & 8'hF0};
        if (lo > 16'h09) begin
            hi = hi + 16'h10;
            lo = lo + 16'h06;
        end
        if (hi > 16'h90) hi = hi + 16'h60;
        put_flag(FC, (hi & 16'hFF00) != 16'h0000);
        r = {hi[7:4], lo[3:0]};
        set_nz(r);
        a_r = r;
    endfunction

    function automatic void sbc_dec(logic [7:0] v);
        logic [15:0] r;
        r = {8'd0, a_r} - {12'd0, v[3:0]} + {15'd0, p_r[0]} - 16'd1;
        if (r[3:0] > a_r[3:0]) r = r - 16'd6;
        r = r - {8'd0, v & 8'hF0};
        if ((r & 16'hFFF0) > {8'd0, a_r & 8'hF0}) r = r - 16'h60;
        put_flag(FC, r <= {8'd0, a_r});
        set_nz(r[7:0]);
        a_r = r[7:0];
    endfunction

    function automatic cbeu_pkg::t_out_word exec_word(cbeu_pkg::t_in_word w);
        cbeu_pkg::t_out_word o;
        logic [7:0]  v, r, lo8;
        logic [15:0] pc, t;
        logic        wr, modify, take;
        logic [7:0]  wd;
        v = w.operand;
        pc = w.next_pc;
        wr = 1'b0; wd = 8'h00; modify = 1'b0; take = 1'b0; r = 8'h00;
        case (w.op)
            cbeu_pkg::OP_ADC: if ((p_r & FD) != 8'h00) adc_dec(v); else add_bin(v);
            cbeu_pkg::OP_SBC: if ((p_r & FD) != 8'h00) sbc_dec(v); else add_bin(~v);
            cbeu_pkg::OP_AND: begin a_r = a_r & v; set_nz(a_r); end
            cbeu_pkg::OP_ORA: begin a_r = a_r | v; set_nz(a_r); end
            cbeu_pkg::OP_EOR: begin a_r = a_r ^ v; set_nz(a_r); end
            cbeu_pkg::OP_ASL: begin r = {v[6:0], 1'b0}; put_flag(FC, v[7]); modify = 1'b1; end
            cbeu_pkg::OP_ROL: begin r = {v[6:0], p_r[0]}; put_flag(FC, v[7]); modify = 1'b1; end
            cbeu_pkg::OP_LSR: begin r = {1'b0, v[7:1]}; put_flag(FC, v[0]); modify = 1'b1; end
            cbeu_pkg::OP_ROR: begin r = {p_r[0], v[7:1]}; put_flag(FC, v[0]); modify = 1'b1; end
            cbeu_pkg::OP_INC: begin r = v + 8'd1; modify = 1'b1; end
            cbeu_pkg::OP_DEC: begin r = v - 8'd1; modify = 1'b1; end
            cbeu_pkg::OP_BCC: take = !p_r[0];
            cbeu_pkg::OP_BCS: take = p_r[0];
            cbeu_pkg::OP_BEQ: take = p_r[1];
            cbeu_pkg::OP_BNE: take = !p_r[1];
            cbeu_pkg::OP_BMI: take = p_r[7];
            cbeu_pkg::OP_BPL: take = !p_r[7];
            cbeu_pkg::OP_BVC: take = !p_r[6];
            cbeu_pkg::OP_BVS: take = p_r[6];
            cbeu_pkg::OP_BIT: begin
                put_flag(FZ, (a_r & v) == 8'h00);
                p_r = (p_r & 8'h3F) | (v & 8'hC0);
            end
            cbeu_pkg::OP_BRK: begin
                t = pc + 16'd1;
                push8(t[15:8]); push8(t[7:0]);
                push8(p_r | cbeu_pkg::FlB);
                put_flag(FI, 1'b1); put_flag(FD, 1'b0);
                pc = brk_vec;
            end
            cbeu_pkg::OP_CLC: put_flag(FC, 1'b0);
            cbeu_pkg::OP_CLD: put_flag(FD, 1'b0);
            cbeu_pkg::OP_CLI: put_flag(FI, 1'b0);
            cbeu_pkg::OP_CLV: put_flag(FV, 1'b0);
            cbeu_pkg::OP_SEC: put_flag(FC, 1'b1);
            cbeu_pkg::OP_SED: put_flag(FD, 1'b1);
            cbeu_pkg::OP_SEI: put_flag(FI, 1'b1);
            cbeu_pkg::OP_CMP: compare(a_r, v);
            cbeu_pkg::OP_CPX: compare(x_r, v);
            cbeu_pkg::OP_CPY: compare(y_r, v);
            cbeu_pkg::OP_DEX: begin x_r = x_r - 8'd1; set_nz(x_r); end
            cbeu_pkg::OP_DEY: begin y_r = y_r - 8'd1; set_nz(y_r); end
            cbeu_pkg::OP_INX: begin x_r = x_r + 8'd1; set_nz(x_r); end
            cbeu_pkg::OP_INY: begin y_r = y_r + 8'd1; set_nz(y_r); end
            cbeu_pkg::OP_JMP: pc = w.target;
            cbeu_pkg::OP_JSR: begin
                t = pc - 16'd1;
                push8(t[15:8]); push8(t[7:0]);
                pc = w.target;
            end
            cbeu_pkg::OP_RTS: begin
                lo8 = pull8();
                t = {pull8(), lo8};
                pc = t + 16'd1;
            end
            cbeu_pkg::OP_RTI: begin
                p_r = pull8();
                lo8 = pull8();
                pc = {pull8(), lo8};
            end
            cbeu_pkg::OP_LDA: begin a_r = v; set_nz(a_r); end
            cbeu_pkg::OP_LDX: begin x_r = v; set_nz(x_r); end
            cbeu_pkg::OP_LDY: begin y_r = v; set_nz(y_r); end
            cbeu_pkg::OP_PHA: push8(a_r);
            cbeu_pkg::OP_PHP: push8(p_r | cbeu_pkg::FlB);
            cbeu_pkg::OP_PLA: begin a_r = pull8(); set_nz(a_r); end
            cbeu_pkg::OP_PLP: p_r = pull8() | cbeu_pkg::Fl1;
            cbeu_pkg::OP_STA: begin wr = 1'b1; wd = a_r; end
            cbeu_pkg::OP_STX: begin wr = 1'b1; wd = x_r; end
            cbeu_pkg::OP_STY: begin wr = 1'b1; wd = y_r; end
            cbeu_pkg::OP_TAX: begin x_r = a_r; set_nz(x_r); end
            cbeu_pkg::OP_TAY: begin y_r = a_r; set_nz(y_r); end
            cbeu_pkg::OP_TSX: begin x_r = sp_r; set_nz(x_r); end
            cbeu_pkg::OP_TXA: begin a_r = x_r; set_nz(a_r); end
            cbeu_pkg::OP_TXS: sp_r = x_r;
            cbeu_pkg::OP_TYA: begin a_r = y_r; set_nz(a_r); end
            default: ;
        endcase
        if (modify) begin
            set_nz(r);
            if (w.acc_mode) a_r = r;
            else begin
                wr = 1'b1;
                wd = r;
            end
        end
        if (take) pc = pc + {{8{w.offset[7]}}, w.offset};
        o.mem_write = wr;
        o.mem_data  = wd;
        o.new_pc    = pc;
        o.acc       = a_r;
        o.index_x   = x_r;
        o.index_y   = y_r;
        o.flags     = p_r;
        o.stack_ptr = sp_r;
        return o;
    endfunction

    always @(posedge i_clk) begin
        cbeu_pkg::t_out_word e;
        if (!i_rst_n) begin
            a_r = 8'h00; x_r = 8'h00; y_r = 8'h00;
            sp_r = cbeu_pkg::SpReset; p_r = cbeu_pkg::PReset;
            brk_vec = 16'h0000;
            for (int i = 0; i < 256; i++) stk[i] = 8'h00;
            exp_words.delete();
            errors = 0;
            pending = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (exp_words.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word %h", o_out);
                end else begin
                    e = exp_words.pop_front();
                    if (e !== o_out) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp %h got %h", e, o_out);
                    end
                end
            end
            if (i_valid && !o_stall) exp_words.push_back(exec_word(i_in));
            if (psel && penable && pwrite && pready && paddr == cbeu_pkg::RegBvAddr)
                brk_vec = pwdata[15:0];
            pending = exp_words.size();
        end
    end
endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

    logic                i_clk = 0, i_rst_n = 0;
    logic                i_valid = 0, i_stall = 0;
    logic                o_stall, o_valid, pready;
    cbeu_pkg::t_in_word  i_in = '0;
    cbeu_pkg::t_out_word o_out;
    logic                psel = 0, penable = 0, pwrite = 0;
    logic [2:0]          paddr = 0;
    logic [31:0]         pwdata = 0, prdata;
    int                  errors, pending, cycles = 0;
    int                  stall_left = 0;
    logic                calm = 0;

    always #6 i_clk = ~i_clk;

    cpu_8bit_bcd_execute_unit dut (.*);

    cbeu_checker chk (.*, .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("FAIL cpu_8bit_bcd_execute_unit");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (calm) stall_left = 0;
        else if (stall_left == 0 && !i_stall && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 3);
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic write_vec(logic [15:0] v);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= cbeu_pkg::RegBvAddr;
        pwdata <= {16'h0000, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send(cbeu_pkg::t_in_word w);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic cbeu_pkg::t_in_word rand_word(int op);
        cbeu_pkg::t_in_word w;
        w.op       = cbeu_pkg::t_op'(op[5:0]);
        w.operand  = 8'($urandom());
        w.acc_mode = 1'($urandom());
        w.target   = 16'($urandom());
        w.offset   = 8'($urandom());
        w.next_pc  = 16'($urandom());
        return w;
    endfunction

    function automatic cbeu_pkg::t_in_word op_word(cbeu_pkg::t_op op, logic [7:0] v);
        cbeu_pkg::t_in_word w;
        w = rand_word(int'(op));
        w.operand = v;
        return w;
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    initial begin
        cbeu_pkg::t_in_word w;
        int op;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        write_vec(16'hFFFF);
        send(op_word(cbeu_pkg::OP_LDA, 8'h00));
        send(op_word(cbeu_pkg::OP_ADC, 8'hFF));
        send(op_word(cbeu_pkg::OP_SED, 8'h00));
        send(op_word(cbeu_pkg::OP_ADC, 8'h99));
        send(op_word(cbeu_pkg::OP_SBC, 8'h01));
        send(op_word(cbeu_pkg::OP_CLD, 8'h00));
        send(op_word(cbeu_pkg::OP_BIT, 8'hC0));
        send(op_word(cbeu_pkg::OP_BRK, 8'h00));
        send(op_word(cbeu_pkg::OP_RTI, 8'h00));
        w = op_word(cbeu_pkg::OP_ASL, 8'h80); w.acc_mode = 1'b1; send(w);
        w = op_word(cbeu_pkg::OP_ROR, 8'h01); w.acc_mode = 1'b0; send(w);
        w = op_word(cbeu_pkg::OP_STA, 8'h00); w.acc_mode = 1'b1; send(w);
        send(op_word(cbeu_pkg::OP_PHP, 8'h00));
        send(op_word(cbeu_pkg::OP_PLP, 8'h00));
        w = op_word(cbeu_pkg::OP_BEQ, 8'h00); w.offset = 8'sh80; w.next_pc = 16'h0000;
        send(w);
        w = op_word(cbeu_pkg::OP_BNE, 8'h00); w.offset = 8'sh7F; w.next_pc = 16'hFFFF;
        send(w);
        w = op_word(cbeu_pkg::OP_JSR, 8'h00); w.target = 16'hFFFF; send(w);
        send(op_word(cbeu_pkg::OP_RTS, 8'h00));
        send(rand_word(56));
        send(rand_word(63));
        drain();
        write_vec(16'h0000);
        for (int i = 0; i < 640; i++) begin
            if (i == 320) begin
                drain();
                write_vec(16'($urandom()));
            end
            if (i == 560) calm = 1;
            op = $urandom_range(0, 63);
            send(rand_word(op));
        end
        calm = 1;
        drain();
        if (errors == 0) $display("PASS cpu_8bit_bcd_execute_unit");
        else $display("FAIL cpu_8bit_bcd_execute_unit");
        $finish;
    end
endmodule

/* files.f */
+incdir+sv
sv/cbeu_pkg.sv
sv/cbeu_ram.sv
sv/cbeu_alu.sv
sv/cpu_8bit_bcd_execute_unit.sv
sv/cbeu_checker.sv
verif/cbeu_checker.sv
verif/tb_top.sv
